[rtl/kde_pkg.sv]
// Shared types, codes and defaults of the key debounce event queue.
// No dependencies; every other rtl file refers to it by scoped names.
package kde_pkg;

   localparam int NUM_KEYS_DEF    = 8;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int OPCODE_W = 2;
   localparam int KEY_W    = 3;
   localparam int CODE_W   = 8;
   localparam int CSR_W    = 16;

   localparam logic [6:0]  FILTER_TIME_RST   = 7'd5;
   localparam logic [15:0] LONG_TIME_RST     = 16'd100;
   localparam logic [7:0]  REPEAT_PERIOD_RST = 8'd5;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_FILTER_TIME   = 2'd0,
      CSR_LONG_TIME     = 2'd1,
      CSR_REPEAT_PERIOD = 2'd2,
      CSR_NONE          = 2'd3
   } csr_index_type;

   localparam logic [1:0] KIND_PRESS   = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;
   localparam logic [1:0] KIND_LONG    = 2'd3;

   typedef struct packed {
      logic [6:0]  filter_time;
      logic [15:0] long_time;
      logic [7:0]  repeat_period;
   } cfg_type;

   typedef struct packed {
      logic        held;
      logic [7:0]  debounce;
      logic [15:0] long_cnt;
      logic [7:0]  repeat_cnt;
   } key_state_type;

   typedef struct packed {
      key_state_type next;
      logic [1:0]    ev_count;
      logic [1:0]    ev0_kind;
      logic [1:0]    ev1_kind;
   } key_update_type;

   typedef struct packed {
      logic              push;
      logic [CODE_W-1:0] code;
      logic              dequeue;
      logic              clear;
   } ring_cmd_type;

endpackage

[rtl/kde_key_store.sv]
// Per-key state memory: synchronous read, one write port, valid bits for reset.
// Forwards a write that lands on the key being read in the same cycle.
// Depends on kde_pkg.
module kde_key_store #(
   parameter int NUM_KEYS = kde_pkg::NUM_KEYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [kde_pkg::KEY_W-1:0] rd_key,
   output kde_pkg::key_state_type rd_state,
   input  logic                  wr_en,
   input  logic [kde_pkg::KEY_W-1:0] wr_key,
   input  kde_pkg::key_state_type wr_state
);

   localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   kde_pkg::key_state_type mem [NUM_KEYS];
   logic [NUM_KEYS-1:0]    valid_ff;
   logic [NUM_KEYS-1:0]    valid_in;
   kde_pkg::key_state_type rd_data_ff;
   logic                   rd_valid_ff;
   logic                   fwd_ff;
   kde_pkg::key_state_type fwd_state_ff;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;

   assign rd_addr = ADDR_W'(rd_key);
   assign wr_addr = ADDR_W'(wr_key);

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
            fwd_ff      <= wr_en && (wr_key == rd_key);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_state;
      end
      if (rd_en) begin
         rd_data_ff   <= mem[rd_addr];
         fwd_state_ff <= wr_state;
      end
   end

   // never-written entries read as the reset state
   assign rd_state = fwd_ff      ? fwd_state_ff :
                     rd_valid_ff ? rd_data_ff   : '0;

endmodule

[rtl/kde_key_update.sv]
// Debounce, long-press and repeat next-state logic for one key and one tick.
// Pure combinational; depends on kde_pkg.
module kde_key_update (
   input  kde_pkg::key_state_type  cur,
   input  logic                    pressed,
   input  kde_pkg::cfg_type        cfg,
   output kde_pkg::key_update_type upd
);

   logic [7:0]  ft;
   logic [7:0]  ft2;
   logic [15:0] long_inc;
   logic [7:0]  rep_inc;
   logic        press_new;
   logic        long_fire;
   logic        rep_fire;

   assign ft       = {1'b0, cfg.filter_time};
   assign ft2      = {cfg.filter_time, 1'b0};
   assign long_inc = cur.long_cnt + 16'd1;
   assign rep_inc  = cur.repeat_cnt + 8'd1;

   always_comb begin
      upd       = '0;
      upd.next  = cur;
      press_new = 1'b0;
      long_fire = 1'b0;
      rep_fire  = 1'b0;
      if (pressed) begin
         priority if (cur.debounce < ft) begin
            upd.next.debounce = ft;
         end else if (cur.debounce < ft2) begin
            upd.next.debounce = cur.debounce + 8'd1;
         end else begin
            press_new     = !cur.held;
            upd.next.held = 1'b1;
            if (cfg.long_time != 16'd0) begin
               priority if (cur.long_cnt < cfg.long_time) begin
                  upd.next.long_cnt = long_inc;
                  long_fire         = (long_inc == cfg.long_time);
               end else if (cfg.repeat_period != 8'd0) begin
                  rep_fire            = (rep_inc >= cfg.repeat_period);
                  upd.next.repeat_cnt = rep_fire ? 8'd0 : rep_inc;
               end else begin
                  upd.next.repeat_cnt = cur.repeat_cnt;
               end
            end
         end
      end else begin
         priority if (cur.debounce > ft) begin
            upd.next.debounce = ft;
         end else if (cur.debounce != 8'd0) begin
            upd.next.debounce = cur.debounce - 8'd1;
         end else if (cur.held) begin
            upd.next.held = 1'b0;
         end else begin
            upd.next.held = cur.held;
         end
         upd.next.long_cnt   = '0;
         upd.next.repeat_cnt = '0;
      end

      // a fresh press can only pair with the long-press event
      upd.ev_count = 2'(press_new) + 2'(long_fire) + 2'(rep_fire);
      upd.ev1_kind = kde_pkg::KIND_LONG;
      priority if (!pressed) begin
         upd.ev_count = 2'(cur.debounce <= ft && cur.debounce == 8'd0 && cur.held);
         upd.ev0_kind = kde_pkg::KIND_RELEASE;
      end else if (press_new) begin
         upd.ev0_kind = kde_pkg::KIND_PRESS;
      end else if (long_fire) begin
         upd.ev0_kind = kde_pkg::KIND_LONG;
      end else begin
         upd.ev0_kind = kde_pkg::KIND_PRESS;
      end
   end

endmodule

[rtl/kde_event_ring.sv]
// Event ring memory with read and write pointers and registered read data.
// One push, dequeue or clear per cycle; depends on kde_pkg.
module kde_event_ring #(
   parameter int QUEUE_DEPTH = kde_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  kde_pkg::ring_cmd_type       cmd,
   output logic [kde_pkg::CODE_W-1:0]  rd_code,
   output logic                        rd_empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [kde_pkg::CODE_W-1:0] mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]           rd_ptr_ff;
   logic [PTR_W-1:0]           rd_ptr_in;
   logic [PTR_W-1:0]           wr_ptr_ff;
   logic [PTR_W-1:0]           wr_ptr_in;
   logic [kde_pkg::CODE_W-1:0] rd_data_ff;
   logic                       empty_ff;
   logic                       empty_now;

   assign empty_now = (rd_ptr_ff == wr_ptr_ff);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (cmd.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (cmd.dequeue && !empty_now) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (cmd.clear) begin
         rd_ptr_in = wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_ptr_ff] <= cmd.code;
      end
      if (cmd.dequeue) begin
         empty_ff <= empty_now;
         if (!empty_now) begin
            rd_data_ff <= mem[rd_ptr_ff];
         end
      end
   end

   assign rd_code  = empty_ff ? '0 : rd_data_ff;
   assign rd_empty = empty_ff;

endmodule

[rtl/key_debounce_event_queue.sv]
// Key debounce with long-press and repeat detection feeding a shared event ring.
// Top level: request stage, response register, configuration registers.
// Depends on kde_pkg, kde_key_store, kde_key_update and kde_event_ring.

// Each request is a sample tick for one key, a dequeue or a clear of the event
// queue. Requests are taken one per cycle unless the stage is held: a request
// is accepted into a single processing stage while the key state memory read
// is issued, and from that stage it reads-modifies-writes that key's state (with
// forwarding when consecutive samples hit the same key) and updates the event
// ring. Two cases hold the request stage: a sample whose debounce completes with
// a long-press threshold of one produces both a press and a long-press event
// and needs two ring writes on the single write port, and a dequeue waits while
// the previous response has not been taken. A dequeue response appears in the
// cycle after the dequeue is processed, from a registered ring read; it carries
// the oldest event as (key << 2) + kind (1 press, 2 release, 3 long press) or
// 0 with queue_empty set. Samples, clears and unused opcodes give no response.
// The ring has no full check: after QUEUE_DEPTH unread events it wraps and
// reads as empty. Configuration writes are taken at any time (csr_ready is
// tied high) and must be made while the block is idle.
module key_debounce_event_queue #(
   parameter int NUM_KEYS    = kde_pkg::NUM_KEYS_DEF,
   parameter int QUEUE_DEPTH = kde_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kde_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [kde_pkg::KEY_W-1:0]     req_key_index,
   input  logic                          req_pressed,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kde_pkg::CODE_W-1:0]    rsp_event_code,
   output logic                          rsp_queue_empty,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [kde_pkg::CSR_W-1:0]     csr_wdata
);

   // configuration
   kde_pkg::cfg_type cfg_ff;
   kde_pkg::cfg_type cfg_in;

   // request stage
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   kde_pkg::op_type           s1_op_ff;
   logic [kde_pkg::KEY_W-1:0] s1_key_ff;
   logic                      s1_pressed_ff;
   logic                      s1_phase_ff;
   logic                      s1_phase_in;

   // response register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   logic                      accept;
   logic                      advance;
   logic                      out_free;
   logic                      s1_sample;
   logic                      two_events;
   logic                      deq_fire;

   kde_pkg::key_state_type    key_cur;
   kde_pkg::key_update_type   key_upd;
   kde_pkg::ring_cmd_type     ring_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (kde_pkg::csr_index_type'(csr_index))
            kde_pkg::CSR_FILTER_TIME:   cfg_in.filter_time   = csr_wdata[6:0];
            kde_pkg::CSR_LONG_TIME:     cfg_in.long_time     = csr_wdata;
            kde_pkg::CSR_REPEAT_PERIOD: cfg_in.repeat_period = csr_wdata[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   // stage control: a sample is live only for a key that exists
   assign s1_sample  = s1_valid_ff && (s1_op_ff == kde_pkg::OP_SAMPLE)
                       && (32'(s1_key_ff) < NUM_KEYS);
   assign two_events = s1_sample && (key_upd.ev_count == 2'd2);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = s1_valid_ff
                       && !((s1_op_ff == kde_pkg::OP_DEQUEUE) && !out_free)
                       && !(two_events && !s1_phase_ff);
   assign req_ready  = !s1_valid_ff || advance;
   assign accept     = req_valid && req_ready;
   assign deq_fire   = advance && (s1_op_ff == kde_pkg::OP_DEQUEUE);

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      // hold the first event written, push the second next cycle
      s1_phase_in = (two_events && !s1_phase_ff) ? 1'b1 :
                    (advance ? 1'b0 : s1_phase_ff);
      rsp_valid_in = deq_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_time   <= kde_pkg::FILTER_TIME_RST;
         cfg_ff.long_time     <= kde_pkg::LONG_TIME_RST;
         cfg_ff.repeat_period <= kde_pkg::REPEAT_PERIOD_RST;
         s1_valid_ff          <= 1'b0;
         s1_phase_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         s1_phase_ff  <= s1_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= kde_pkg::op_type'(req_opcode);
         s1_key_ff     <= req_key_index;
         s1_pressed_ff <= req_pressed;
      end
   end

   kde_key_store #(
      .NUM_KEYS (NUM_KEYS)
   ) u_key_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_key   (req_key_index),
      .rd_state (key_cur),
      .wr_en    (advance && s1_sample),
      .wr_key   (s1_key_ff),
      .wr_state (key_upd.next)
   );

   kde_key_update u_key_update (
      .cur     (key_cur),
      .pressed (s1_pressed_ff),
      .cfg     (cfg_ff),
      .upd     (key_upd)
   );

   always_comb begin
      ring_cmd.push    = s1_sample && (s1_phase_ff || (key_upd.ev_count != 2'd0));
      ring_cmd.code    = kde_pkg::CODE_W'({s1_key_ff,
                         (s1_phase_ff ? key_upd.ev1_kind : key_upd.ev0_kind)});
      ring_cmd.dequeue = deq_fire;
      ring_cmd.clear   = advance && (s1_op_ff == kde_pkg::OP_CLEAR);
   end

   kde_event_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_event_ring (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ring_cmd),
      .rd_code  (rsp_event_code),
      .rd_empty (rsp_queue_empty)
   );

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // a blocked dequeue must stall the request side
   a_deq_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_op_ff == kde_pkg::OP_DEQUEUE) && rsp_valid_ff && !rsp_ready)
      |-> !req_ready)
      else $error("request accepted behind a blocked dequeue");

   // second-event phase only exists for a live sample
   a_phase_sample: assert property (@(posedge clock) disable iff (reset)
      s1_phase_ff |-> s1_sample)
      else $error("push phase set without a sample in the stage");

   // a processed dequeue always raises a response
   a_deq_rsp: assert property (@(posedge clock) disable iff (reset)
      deq_fire |=> rsp_valid_ff)
      else $error("dequeue lost its response");

   // the stage never advances in the middle of a two-event sample
   a_two_hold: assert property (@(posedge clock) disable iff (reset)
      (two_events && !s1_phase_ff) |-> !advance)
      else $error("two-event sample left the stage after one push");
`endif

endmodule
